@@ design/apsm_pkg.sv @@
// Shared types and constants for the anchored prefix/suffix matcher.
package apsm_pkg;

  localparam int          PAT_MAX_DEF     = 32;
  localparam longint unsigned SUBJECT_MAX_DEF = 64'd65535;
  localparam int          DEPTH_LIMIT     = 32767;

  // Pattern metacharacters
  localparam logic [7:0] CH_HEAD  = 8'h5E;
  localparam logic [7:0] CH_TAIL  = 8'h24;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_OR    = 8'h7C;
  localparam logic [7:0] CH_ANY   = 8'h2E;

  typedef enum logic [1:0] {
    ACT_PAT   = 2'd0,
    ACT_SUBJ  = 2'd1,
    ACT_CLR   = 2'd2,
    ACT_EMPTY = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_VCHK,
    S_HWALK,
    S_TWALK,
    S_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic pat_step;
    logic pat_clear;
    logic pat_res;
    logic subj_step;
    logic subj_clear;
    logic vchk;
    logic hwalk;
    logic twalk;
    logic verdict;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic head_done;
    logic tail_done;
  } stat_t;

endpackage

@@ design/anchored_prefix_suffix_matcher_unit.sv @@
// Top level of the anchored prefix/suffix matcher.
// Pattern and subject requests are taken one at a time. A request that is not
// the last of its pattern or subject is taken without a stall, so a stream
// runs at one byte per cycle. The last pattern byte, or an empty-pattern
// request, gives a compile status in the cycle after it is taken. The last
// subject byte, or an empty-subject request, starts the verdict walk: a check
// step, then a walk over the head positions the stream did not reach, then a
// walk over the tail table positions when the tail anchor is set; a check that
// has already failed ends either walk at once. The walk over the tail table
// reads one stored subject byte per cycle, and the verdict is offered in the
// cycle after the walk ends. No new request is taken from the moment a result
// is due until that result has been taken.
module anchored_prefix_suffix_matcher_unit #(
  parameter int              PAT_MAX     = apsm_pkg::PAT_MAX_DEF,
  parameter longint unsigned SUBJECT_MAX = apsm_pkg::SUBJECT_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_action,
  input  logic [7:0] in_data_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_kind,
  output logic       out_pattern_error,
  output logic       out_matched
);
  import apsm_pkg::*;

  cmd_t  cmd;
  stat_t st;

  apsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_action (in_action),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .st        (st)
  );

  apsm_dp #(
    .PAT_MAX     (PAT_MAX),
    .SUBJECT_MAX (SUBJECT_MAX)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .data_byte (in_data_byte),
    .cmd       (cmd),
    .st        (st),
    .res_kind  (out_kind),
    .res_err   (out_pattern_error),
    .res_match (out_matched)
  );

endmodule

@@ design/apsm_ctrl.sv @@
// Sequencing FSM: request decode, verdict walk steps and result handshake.
module apsm_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      in_action,
  input  logic            in_last,
  output logic            out_valid,
  input  logic            out_stall,
  output apsm_pkg::cmd_t  cmd,
  input  apsm_pkg::stat_t st
);
  import apsm_pkg::*;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          case (action_t'(in_action))
            ACT_PAT: begin
              cmd.pat_step = 1'b1;
              cmd.pat_res  = in_last;
              if (in_last) state_nxt = S_DONE;
            end
            ACT_CLR: begin
              cmd.pat_clear = 1'b1;
              cmd.pat_res   = 1'b1;
              state_nxt     = S_DONE;
            end
            ACT_SUBJ: begin
              cmd.subj_step = 1'b1;
              if (in_last) state_nxt = S_VCHK;
            end
            ACT_EMPTY: begin
              cmd.subj_clear = 1'b1;
              state_nxt      = S_VCHK;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_VCHK: begin
        cmd.vchk  = 1'b1;
        state_nxt = S_HWALK;
      end
      S_HWALK: begin
        cmd.hwalk = 1'b1;
        if (st.head_done) state_nxt = S_TWALK;
      end
      S_TWALK: begin
        cmd.twalk = 1'b1;
        if (st.tail_done) begin
          cmd.verdict = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_DONE: begin
        out_valid = 1'b1;
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // A result waiting at the output blocks new requests
  a_done_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("request taken while result pending");

  // Last pattern byte yields a status right after
  a_pat_res: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_action == ACT_PAT && in_last) |=> out_valid)
    else $error("missing compile status");

  // Walk commands never overlap
  a_walk_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.hwalk && cmd.twalk) && !(cmd.vchk && cmd.verdict))
    else $error("overlapping walk commands");

endmodule

@@ design/apsm_dp.sv @@
// Datapath: pattern tables, compile context, subject tracking and verdict walk.
module apsm_dp #(
  parameter int              PAT_MAX     = apsm_pkg::PAT_MAX_DEF,
  parameter longint unsigned SUBJECT_MAX = apsm_pkg::SUBJECT_MAX_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [7:0]      data_byte,
  input  apsm_pkg::cmd_t  cmd,
  output apsm_pkg::stat_t st,
  output logic            res_kind,
  output logic            res_err,
  output logic            res_match
);
  import apsm_pkg::*;

  localparam int LW = $clog2(PAT_MAX + 1);
  localparam int RW = $clog2(PAT_MAX);
  localparam int CW = $clog2(SUBJECT_MAX + 1);
  localparam int MW = (CW > LW) ? CW : LW;

  typedef enum logic [1:0] {TBL_HC, TBL_HA, TBL_TC, TBL_TA} tbl_t;

  // Tables and subject ring
  logic [7:0] hc_r [PAT_MAX];
  logic [7:0] ha_r [PAT_MAX];
  logic [7:0] tc_r [PAT_MAX];
  logic [7:0] ta_r [PAT_MAX];
  logic [7:0] ring_r [PAT_MAX];

  // Compile context
  logic [LW-1:0]      hl_r, hl_nxt, tl_r, tl_nxt, alti_r, alti_nxt;
  logic [1:0]         anc_r, anc_nxt;
  logic               side_r, side_nxt, altm_r, altm_nxt, ovf_r, ovf_nxt;
  logic               inpat_r, inpat_nxt;
  logic signed [15:0] depth_r, depth_nxt;

  // Subject progress
  logic [LW-1:0] pos_r, pos_nxt;
  logic          skip_r, skip_nxt, mism_r, mism_nxt, ovr_r, ovr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [RW-1:0] wr_r, wr_nxt;

  // Verdict walk
  logic          vfail_r, vfail_nxt;
  logic [LW-1:0] ti_r, ti_nxt, rem_r, rem_nxt;
  logic [RW-1:0] rp_r, rp_nxt;

  // Result register
  logic res_kind_r, res_kind_nxt, res_err_r, res_err_nxt, res_match_r, res_match_nxt;

  // Table write controls
  logic          tbl_clr, wr_en;
  tbl_t          wr_sel;
  logic [RW-1:0] wr_idx;
  logic          ring_we;

  // Read ports
  logic [7:0] h_ch, h_alt, t_ch, t_alt, t_byte;
  logic       clr_subj;
  logic [LW-1:0] lit_idx;
  logic [LW:0]   rp_sum;
  logic [RW:0]   rp_adv;
  logic          adv2;

  assign h_ch   = hc_r[pos_r[RW-1:0]];
  assign h_alt  = ha_r[pos_r[RW-1:0]];
  assign t_ch   = tc_r[ti_r[RW-1:0]];
  assign t_alt  = ta_r[ti_r[RW-1:0]];
  assign t_byte = (rem_r != '0) ? ring_r[rp_r] : 8'h00;

  assign st.head_done = (pos_r >= hl_r) || vfail_r;
  assign st.tail_done = !anc_r[1] || (ti_r >= tl_r) || vfail_r;

  // Next-state logic for all request and walk steps
  always_comb begin
    tbl_clr  = cmd.pat_clear || (cmd.pat_step && !inpat_r);
    clr_subj = tbl_clr || cmd.subj_clear || cmd.verdict;
    wr_en    = 1'b0;
    wr_sel   = TBL_HC;
    wr_idx   = '0;
    ring_we  = 1'b0;
    lit_idx  = '0;
    rp_sum   = '0;
    rp_adv   = '0;
    adv2     = 1'b0;

    hl_nxt    = tbl_clr ? '0 : hl_r;
    tl_nxt    = tbl_clr ? '0 : tl_r;
    alti_nxt  = tbl_clr ? '0 : alti_r;
    anc_nxt   = tbl_clr ? '0 : anc_r;
    side_nxt  = tbl_clr ? 1'b0 : side_r;
    altm_nxt  = tbl_clr ? 1'b0 : altm_r;
    ovf_nxt   = tbl_clr ? 1'b0 : ovf_r;
    depth_nxt = tbl_clr ? '0 : depth_r;
    inpat_nxt = cmd.pat_clear ? 1'b0 : inpat_r;

    pos_nxt  = pos_r;
    skip_nxt = skip_r;
    mism_nxt = mism_r;
    ovr_nxt  = ovr_r;
    cnt_nxt  = cnt_r;
    wr_nxt   = wr_r;

    vfail_nxt = vfail_r;
    ti_nxt    = ti_r;
    rem_nxt   = rem_r;
    rp_nxt    = rp_r;

    res_kind_nxt  = res_kind_r;
    res_err_nxt   = res_err_r;
    res_match_nxt = res_match_r;

    // Pattern byte compile
    if (cmd.pat_step) begin
      inpat_nxt = 1'b1;
      if (data_byte == CH_HEAD) begin
        anc_nxt[0] = 1'b1;
        side_nxt   = 1'b0;
      end else if (data_byte == CH_TAIL) begin
        anc_nxt[1] = 1'b1;
        side_nxt   = 1'b1;
      end else if (data_byte == CH_CLOSE) begin
        if (depth_nxt > -16'(DEPTH_LIMIT)) depth_nxt = depth_nxt - 16'sd1;
        else ovf_nxt = 1'b1;
        alti_nxt = '0;
        altm_nxt = 1'b0;
      end else if (data_byte == CH_OPEN) begin
        if (depth_nxt < 16'(DEPTH_LIMIT)) depth_nxt = depth_nxt + 16'sd1;
        else ovf_nxt = 1'b1;
        alti_nxt = side_nxt ? tl_nxt : hl_nxt;
      end else if (data_byte == CH_OR) begin
        altm_nxt = 1'b1;
      end else begin
        lit_idx = altm_nxt ? alti_nxt : (side_nxt ? tl_nxt : hl_nxt);
        if (lit_idx < LW'(PAT_MAX)) begin
          wr_en  = 1'b1;
          wr_idx = lit_idx[RW-1:0];
          if (altm_nxt) begin
            wr_sel   = side_nxt ? TBL_TA : TBL_HA;
            alti_nxt = alti_nxt + 1'b1;
          end else if (side_nxt) begin
            wr_sel = TBL_TC;
            tl_nxt = tl_nxt + 1'b1;
          end else begin
            wr_sel = TBL_HC;
            hl_nxt = hl_nxt + 1'b1;
          end
        end else begin
          ovf_nxt = 1'b1;
        end
      end
      if (cmd.pat_res) inpat_nxt = 1'b0;
    end

    if (cmd.pat_res) begin
      res_kind_nxt  = 1'b0;
      res_err_nxt   = cmd.pat_step && ((depth_nxt != 16'sd0) || ovf_nxt);
      res_match_nxt = 1'b0;
    end

    if (clr_subj) begin
      pos_nxt  = '0;
      skip_nxt = 1'b0;
      mism_nxt = 1'b0;
      ovr_nxt  = 1'b0;
      cnt_nxt  = '0;
    end

    // Subject byte: prefix step and ring write
    if (cmd.subj_step) begin
      if (skip_r) begin
        skip_nxt = 1'b0;
      end else if (pos_r < hl_r) begin
        if (h_ch == CH_ANY) begin
          if (data_byte[7]) skip_nxt = 1'b1;
        end else if (h_ch != data_byte && h_alt != data_byte) begin
          mism_nxt = 1'b1;
        end
        pos_nxt = pos_r + 1'b1;
      end else begin
        ovr_nxt = 1'b1;
      end
      ring_we = 1'b1;
      wr_nxt  = (wr_r == RW'(PAT_MAX - 1)) ? '0 : wr_r + 1'b1;
      if (cnt_r != CW'(SUBJECT_MAX)) cnt_nxt = cnt_r + 1'b1;
    end

    // Verdict setup: quick checks and tail walk start
    if (cmd.vchk) begin
      vfail_nxt = (MW'(cnt_r) < MW'(hl_r)) || mism_r
               || (!anc_r[0] && hl_r != '0 && (pos_r < hl_r || skip_r || ovr_r))
               || (anc_r[1] && MW'(cnt_r) < MW'(tl_r));
      rp_sum = (LW+1)'(wr_r) + (LW+1)'(PAT_MAX) - (LW+1)'(tl_r);
      if (rp_sum >= (LW+1)'(PAT_MAX)) rp_sum = rp_sum - (LW+1)'(PAT_MAX);
      rp_nxt  = rp_sum[RW-1:0];
      rem_nxt = tl_r;
      ti_nxt  = '0;
    end

    // Head walk over positions the stream did not reach
    if (cmd.hwalk && !st.head_done) begin
      if (h_ch != CH_ANY && h_ch != 8'h00 && h_alt != 8'h00) vfail_nxt = 1'b1;
      pos_nxt = pos_r + 1'b1;
    end

    // Tail walk, one table position a cycle
    if (cmd.twalk && !st.tail_done) begin
      if (t_ch == CH_ANY) begin
        adv2 = t_byte[7];
      end else if (t_ch != t_byte && t_alt != t_byte) begin
        vfail_nxt = 1'b1;
      end
      rp_adv = (RW+1)'(rp_r) + (RW+1)'(1) + (RW+1)'(adv2);
      if (rp_adv >= (RW+1)'(PAT_MAX)) rp_adv = rp_adv - (RW+1)'(PAT_MAX);
      rp_nxt = rp_adv[RW-1:0];
      if (rem_r > LW'(32'd1 + 32'(adv2))) rem_nxt = rem_r - LW'(32'd1 + 32'(adv2));
      else rem_nxt = '0;
      ti_nxt = ti_r + 1'b1;
    end

    if (cmd.verdict) begin
      res_kind_nxt  = 1'b1;
      res_err_nxt   = 1'b0;
      res_match_nxt = !vfail_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hl_r    <= '0;
      tl_r    <= '0;
      alti_r  <= '0;
      anc_r   <= '0;
      side_r  <= 1'b0;
      altm_r  <= 1'b0;
      ovf_r   <= 1'b0;
      inpat_r <= 1'b0;
      depth_r <= '0;
      pos_r   <= '0;
      skip_r  <= 1'b0;
      mism_r  <= 1'b0;
      ovr_r   <= 1'b0;
      cnt_r   <= '0;
      wr_r    <= '0;
      vfail_r <= 1'b0;
      ti_r    <= '0;
    end else begin
      hl_r    <= hl_nxt;
      tl_r    <= tl_nxt;
      alti_r  <= alti_nxt;
      anc_r   <= anc_nxt;
      side_r  <= side_nxt;
      altm_r  <= altm_nxt;
      ovf_r   <= ovf_nxt;
      inpat_r <= inpat_nxt;
      depth_r <= depth_nxt;
      pos_r   <= pos_nxt;
      skip_r  <= skip_nxt;
      mism_r  <= mism_nxt;
      ovr_r   <= ovr_nxt;
      cnt_r   <= cnt_nxt;
      wr_r    <= wr_nxt;
      vfail_r <= vfail_nxt;
      ti_r    <= ti_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rem_r       <= rem_nxt;
    rp_r        <= rp_nxt;
    res_kind_r  <= res_kind_nxt;
    res_err_r   <= res_err_nxt;
    res_match_r <= res_match_nxt;
  end

  // Tables: cleared at a new pattern, one write per compiled literal
  always_ff @(posedge clk) begin
    if (tbl_clr) begin
      for (int i = 0; i < PAT_MAX; i++) begin
        hc_r[i] <= 8'h00;
        ha_r[i] <= 8'h00;
        tc_r[i] <= 8'h00;
        ta_r[i] <= 8'h00;
      end
    end
    if (wr_en) begin
      case (wr_sel)
        TBL_HC:  hc_r[wr_idx] <= data_byte;
        TBL_HA:  ha_r[wr_idx] <= data_byte;
        TBL_TC:  tc_r[wr_idx] <= data_byte;
        TBL_TA:  ta_r[wr_idx] <= data_byte;
        default: hc_r[wr_idx] <= data_byte;
      endcase
    end
  end

  // Recent subject bytes
  always_ff @(posedge clk) begin
    if (ring_we) ring_r[wr_r] <= data_byte;
  end

  assign res_kind  = res_kind_r;
  assign res_err   = res_err_r;
  assign res_match = res_match_r;

  // Table fill never passes the table size
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hl_r <= LW'(PAT_MAX) && tl_r <= LW'(PAT_MAX)) else $error("table length overrun");

  // Tail walk index stays within the tail table
  a_ti_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.twalk |-> ti_r <= tl_r) else $error("tail walk past table");

endmodule
